// ----- rtl/page_stride_prefetcher_macros.svh -----
// ============================================================================
// page_stride_prefetcher_macros.svh
// Assertion macros used by the prefetcher top level.
// ============================================================================
`ifndef PAGE_STRIDE_PREFETCHER_MACROS_SVH
`define PAGE_STRIDE_PREFETCHER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Plain clocked property, disabled during reset
`define PSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication form
`define PSP_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define PSP_ASSERT(label, prop, msg)
`define PSP_ASSERT_IMP(label, pre, post, msg)
`endif
`endif

// ----- rtl/psp_pkg.sv -----
// ============================================================================
// psp_pkg
// Types and constants of the page stride prefetcher.
// ============================================================================
package psp_pkg;

    localparam int IP_W      = 48;
    localparam int PAGE_W    = 36;
    localparam int SEQ_W     = 32;
    localparam int ROLE_W    = 2;
    localparam int PHASE_W   = 3;
    localparam int CONF_W    = 3;
    localparam int STRIDE_W  = PAGE_W + 1;
    localparam int PRED_W    = PAGE_W + 2;

    localparam int TRK_DEPTH  = 256;
    localparam int TRK_AW     = $clog2(TRK_DEPTH);
    localparam int PEND_DEPTH = 64;
    localparam int PEND_AW    = $clog2(PEND_DEPTH);
    localparam int CNT_W      = $clog2(PEND_DEPTH + 1);

    localparam logic [ROLE_W-1:0]  ROLE_LIMIT   = 2'd3;
    localparam logic [PHASE_W-1:0] PHASE_LIMIT  = 3'd7;
    localparam logic [CONF_W-1:0]  CONF_MAX     = 3'd7;
    localparam logic [CONF_W-1:0]  THRESH_RESET = 3'd2;

    // Item handed from front to back
    typedef struct packed {
        logic              ignore;
        logic [IP_W-1:0]   ip;
        logic [PAGE_W-1:0] vpn;
        logic              accept;
    } psp_item_t;

    // One tracker entry as stored in the RAM
    typedef struct packed {
        logic [IP_W-1:0]     tag;
        logic [PAGE_W-1:0]   last_page;
        logic [STRIDE_W-1:0] stride;
        logic [CONF_W-1:0]   conf;
    } psp_trk_t;

    // One result
    typedef struct packed {
        logic               prefetch_valid;
        logic [PAGE_W-1:0]  prefetch_page;
        logic               prefetch_rejected;
        logic               pend_match;
        logic [SEQ_W-1:0]   lead_distance;
        logic [ROLE_W-1:0]  hit_role;
        logic [PHASE_W-1:0] hit_phase;
        logic               trained;
        logic               duplicate_page;
        logic               dup_prefetch;
        logic               pending_eviction;
    } psp_result_t;

    // Back-end sequencer
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_UPD  = 2'b10
    } psp_state_t;

endpackage

// ----- rtl/psp_ram.sv -----
// ============================================================================
// psp_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module psp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/psp_front.sv -----
// ============================================================================
// psp_front
// Accepts commands, classifies them and queues them for the back end.
// ============================================================================
module psp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        is_demand,
    input  logic [psp_pkg::IP_W-1:0]    instr_pointer,
    input  logic [psp_pkg::PAGE_W-1:0]  access_page,
    input  logic                        issue_accepted,
    output logic                        q_valid,
    output psp_pkg::psp_item_t          q_item,
    input  logic                        q_pop
);

    psp_pkg::psp_item_t ent_reg [2];
    logic               wptr_reg;
    logic               rptr_reg;
    logic [1:0]         cnt_reg;
    logic               push;
    psp_pkg::psp_item_t new_item;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = ent_reg[rptr_reg];

    // Classify: non-demand, reserved role or reserved phase is ignored
    always_comb
    begin
        new_item.ip     = instr_pointer;
        new_item.vpn    = access_page;
        new_item.accept = issue_accepted;
        new_item.ignore = !is_demand
            || (instr_pointer[psp_pkg::ROLE_W-1:0] >= psp_pkg::ROLE_LIMIT)
            || (instr_pointer[psp_pkg::ROLE_W+psp_pkg::PHASE_W-1:psp_pkg::ROLE_W]
                >= psp_pkg::PHASE_LIMIT);
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (q_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !q_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (q_pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= new_item;
        end
    end

endmodule

// ----- rtl/psp_back.sv -----
// ============================================================================
// psp_back
// Tracker update, pending prediction CAM and result generation.
// ============================================================================
module psp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [psp_pkg::CONF_W-1:0]  thresh,
    input  logic                        q_valid,
    input  psp_pkg::psp_item_t          q_item,
    output logic                        q_pop,
    output logic                        done,
    output psp_pkg::psp_result_t        result
);

    psp_pkg::psp_state_t  state_reg, state_next;
    psp_pkg::psp_item_t   cur_reg;
    logic                 hit_reg;
    logic [psp_pkg::SEQ_W-1:0]   lead_reg;
    logic [psp_pkg::ROLE_W-1:0]  hrole_reg;
    logic [psp_pkg::PHASE_W-1:0] hphase_reg;
    logic [psp_pkg::SEQ_W-1:0]   counter_reg;
    logic [psp_pkg::TRK_DEPTH-1:0] tvalid_reg;

    logic [psp_pkg::PEND_DEPTH-1:0] live_reg;
    logic [psp_pkg::PAGE_W-1:0]  page_reg  [psp_pkg::PEND_DEPTH];
    logic [psp_pkg::SEQ_W-1:0]   seq_reg   [psp_pkg::PEND_DEPTH];
    logic [psp_pkg::ROLE_W-1:0]  role_reg  [psp_pkg::PEND_DEPTH];
    logic [psp_pkg::PHASE_W-1:0] phase_reg [psp_pkg::PEND_DEPTH];
    logic [psp_pkg::PEND_AW-1:0] head_reg;
    logic [psp_pkg::CNT_W-1:0]   count_reg;

    psp_pkg::psp_result_t res_reg, res_next;
    logic                 done_reg;

    // Lookup stage signals
    logic                 demand;
    logic [psp_pkg::PEND_DEPTH-1:0] m_vpn;
    logic                 any_hit;
    logic [psp_pkg::SEQ_W-1:0]   h_seq;
    logic [psp_pkg::ROLE_W-1:0]  h_role;
    logic [psp_pkg::PHASE_W-1:0] h_phase;

    // Update stage signals
    logic [$bits(psp_pkg::psp_trk_t)-1:0] ram_rdata;
    psp_pkg::psp_trk_t    rd, wr;
    logic                 upd;
    logic [psp_pkg::TRK_AW-1:0] tidx;
    logic                 miss, dup, train_upd, same, predict, in_range, make;
    logic [psp_pkg::STRIDE_W-1:0] stride_n;
    logic [psp_pkg::CONF_W-1:0]   conf_n;
    logic [psp_pkg::PRED_W-1:0]   pred;
    logic [psp_pkg::PAGE_W-1:0]   pred_page, victim;
    logic [psp_pkg::PEND_DEPTH-1:0] m_pred, m_vic, slot_hot;
    logic                 dup_pred, issue, rej, full, vic_same, evict;
    logic [psp_pkg::PEND_AW-1:0] slot;

    assign q_pop  = (state_reg == psp_pkg::ST_IDLE) && q_valid;
    assign demand = q_pop && !q_item.ignore;
    assign upd    = (state_reg == psp_pkg::ST_UPD);
    assign done   = done_reg;
    assign result = res_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psp_pkg::ST_IDLE:
            begin
                if (demand)
                begin
                    state_next = psp_pkg::ST_UPD;
                end
            end
            psp_pkg::ST_UPD:
            begin
                state_next = psp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = psp_pkg::ST_IDLE;
            end
        endcase
    end

    // Demand CAM lookup; at most one live entry holds a given page
    always_comb
    begin
        h_seq   = '0;
        h_role  = '0;
        h_phase = '0;
        for (int i = 0; i < psp_pkg::PEND_DEPTH; i++)
        begin
            m_vpn[i] = live_reg[i] && (page_reg[i] == q_item.vpn);
            if (m_vpn[i])
            begin
                h_seq   = h_seq   | seq_reg[i];
                h_role  = h_role  | role_reg[i];
                h_phase = h_phase | phase_reg[i];
            end
        end
        any_hit = |m_vpn;
    end

    // Tracker entry store
    psp_ram #(
        .WIDTH ($bits(psp_pkg::psp_trk_t)),
        .DEPTH (psp_pkg::TRK_DEPTH)
    ) u_trk_ram (
        .clk   (clk),
        .we    (upd && (miss || train_upd)),
        .waddr (tidx),
        .wdata (wr),
        .raddr (q_item.ip[psp_pkg::TRK_AW-1:0]),
        .rdata (ram_rdata)
    );

    // Tracker training and prediction
    always_comb
    begin
        rd        = psp_pkg::psp_trk_t'(ram_rdata);
        tidx      = cur_reg.ip[psp_pkg::TRK_AW-1:0];
        miss      = !tvalid_reg[tidx] || (rd.tag != cur_reg.ip);
        dup       = !miss && (cur_reg.vpn == rd.last_page);
        train_upd = !miss && !dup;
        stride_n  = psp_pkg::STRIDE_W'(cur_reg.vpn) - psp_pkg::STRIDE_W'(rd.last_page);
        same      = (stride_n == rd.stride);
        if (!same)
        begin
            conf_n = psp_pkg::CONF_W'(1);
        end
        else if (rd.conf != psp_pkg::CONF_MAX)
        begin
            conf_n = rd.conf + psp_pkg::CONF_W'(1);
        end
        else
        begin
            conf_n = rd.conf;
        end
        wr.tag       = cur_reg.ip;
        wr.last_page = cur_reg.vpn;
        wr.stride    = miss ? '0 : stride_n;
        wr.conf      = miss ? '0 : conf_n;
        // stride is nonzero whenever train_upd holds
        predict   = train_upd && (conf_n >= thresh);
        pred      = {stride_n[psp_pkg::STRIDE_W-1], stride_n}
                    + psp_pkg::PRED_W'(cur_reg.vpn);
        in_range  = (pred[psp_pkg::PRED_W-1:psp_pkg::PAGE_W] == '0);
        pred_page = pred[psp_pkg::PAGE_W-1:0];
        make      = predict && in_range;
    end

    // Prediction CAM check and FIFO victim search
    always_comb
    begin
        full     = (count_reg == psp_pkg::CNT_W'(psp_pkg::PEND_DEPTH));
        slot     = full ? head_reg
                        : psp_pkg::PEND_AW'(head_reg + count_reg[psp_pkg::PEND_AW-1:0]);
        slot_hot       = '0;
        slot_hot[slot] = 1'b1;
        victim   = page_reg[head_reg];
        vic_same = (victim == pred_page);
        for (int i = 0; i < psp_pkg::PEND_DEPTH; i++)
        begin
            m_pred[i] = live_reg[i] && (page_reg[i] == pred_page);
            m_vic[i]  = live_reg[i] && (page_reg[i] == victim);
        end
        dup_pred = make && (|m_pred);
        issue    = make && !dup_pred && cur_reg.accept;
        rej      = make && !dup_pred && !cur_reg.accept;
        evict    = issue && full && (vic_same || (|m_vic));
    end

    // Result assembly
    always_comb
    begin
        res_next                   = '0;
        res_next.pend_match        = hit_reg;
        res_next.lead_distance     = lead_reg;
        res_next.hit_role          = hrole_reg;
        res_next.hit_phase         = hphase_reg;
        res_next.trained           = miss || train_upd;
        res_next.duplicate_page    = dup;
        res_next.prefetch_page     = make ? pred_page : '0;
        res_next.dup_prefetch      = dup_pred;
        res_next.prefetch_rejected = rej;
        res_next.prefetch_valid    = issue;
        res_next.pending_eviction  = evict;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= psp_pkg::ST_IDLE;
            counter_reg <= '0;
            tvalid_reg  <= '0;
            live_reg    <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (q_pop && q_item.ignore) || upd;
            if (demand)
            begin
                counter_reg <= counter_reg + psp_pkg::SEQ_W'(1);
                live_reg    <= live_reg & ~m_vpn;
            end
            if (upd)
            begin
                if (miss)
                begin
                    tvalid_reg[tidx] <= 1'b1;
                end
                if (issue)
                begin
                    if (full)
                    begin
                        head_reg <= head_reg + psp_pkg::PEND_AW'(1);
                        if (!vic_same)
                        begin
                            live_reg       <= (live_reg & ~m_vic) | slot_hot;
                        end
                        else
                        begin
                            live_reg[slot] <= 1'b0;
                        end
                    end
                    else
                    begin
                        count_reg      <= count_reg + psp_pkg::CNT_W'(1);
                        live_reg[slot] <= 1'b1;
                    end
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg    <= q_item;
            hit_reg    <= any_hit;
            lead_reg   <= any_hit ? (counter_reg + psp_pkg::SEQ_W'(1) - h_seq) : '0;
            hrole_reg  <= h_role;
            hphase_reg <= h_phase;
        end
        if (q_pop && q_item.ignore)
        begin
            res_reg <= '0;
        end
        else if (upd)
        begin
            res_reg <= res_next;
        end
        if (upd && issue)
        begin
            page_reg[slot]  <= pred_page;
            seq_reg[slot]   <= counter_reg;
            role_reg[slot]  <= cur_reg.ip[psp_pkg::ROLE_W-1:0];
            phase_reg[slot] <= cur_reg.ip[psp_pkg::ROLE_W+psp_pkg::PHASE_W-1:psp_pkg::ROLE_W];
        end
    end

endmodule

// ----- rtl/page_stride_prefetcher.sv -----
// ============================================================================
// page_stride_prefetcher
// Per instruction-pointer page stride prefetcher, top level.
// ============================================================================
// Usage:
//  - Command channel: an access is taken when start is high and busy is low.
//    A two-entry queue sits behind it, so busy rises only when it is full.
//  - Every access yields one result: done pulses for one cycle with all
//    result ports valid in that cycle. The receiver cannot stall.
//  - Result path: the access is written into the queue; an ignored access
//    (not a demand, role 3 or phase 7) is popped and its result registered,
//    a demand is popped into the update state, which registers its result.
//  - Throughput: ignored accesses one per cycle while the back end is idle;
//    a demand holds it for the tracker RAM read-modify-write (read, update).
//  - Config: cfg_valid/cfg_ready write the 3-bit confidence threshold;
//    cfg_ready is always high. Write only while the block is idle.
//  - Reset: tracker valid bits, pending live bits, FIFO pointers, demand
//    counter are cleared; threshold returns to 2. No clearing pass needed.
// ============================================================================
`include "page_stride_prefetcher_macros.svh"

module page_stride_prefetcher (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        is_demand,
    input  logic [psp_pkg::IP_W-1:0]    instr_pointer,
    input  logic [psp_pkg::PAGE_W-1:0]  access_page,
    input  logic                        issue_accepted,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [psp_pkg::CONF_W-1:0]  cfg_data,
    output logic                        done,
    output logic                        prefetch_valid,
    output logic [psp_pkg::PAGE_W-1:0]  prefetch_page,
    output logic                        prefetch_rejected,
    output logic                        pend_match,
    output logic [psp_pkg::SEQ_W-1:0]   lead_distance,
    output logic [psp_pkg::ROLE_W-1:0]  hit_role,
    output logic [psp_pkg::PHASE_W-1:0] hit_phase,
    output logic                        trained,
    output logic                        duplicate_page,
    output logic                        dup_prefetch,
    output logic                        pending_eviction
);

    logic [psp_pkg::CONF_W-1:0] thresh_reg;
    logic                       q_valid;
    logic                       q_pop;
    psp_pkg::psp_item_t         q_item;
    psp_pkg::psp_result_t       res;

    assign cfg_ready = 1'b1;

    // Confidence threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= psp_pkg::THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thresh_reg <= cfg_data;
        end
    end

    psp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .is_demand      (is_demand),
        .instr_pointer  (instr_pointer),
        .access_page    (access_page),
        .issue_accepted (issue_accepted),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    psp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .thresh  (thresh_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .done    (done),
        .result  (res)
    );

    // Result fields
    assign prefetch_valid    = res.prefetch_valid;
    assign prefetch_page     = res.prefetch_page;
    assign prefetch_rejected = res.prefetch_rejected;
    assign pend_match        = res.pend_match;
    assign lead_distance     = res.lead_distance;
    assign hit_role          = res.hit_role;
    assign hit_phase         = res.hit_phase;
    assign trained           = res.trained;
    assign duplicate_page    = res.duplicate_page;
    assign dup_prefetch      = res.dup_prefetch;
    assign pending_eviction  = res.pending_eviction;

    // Checks
    `PSP_ASSERT_IMP(a_busy_after_transfer, $rose(busy), $past(start), "busy rose without a transfer")
    `PSP_ASSERT_IMP(a_issue_clean, done && prefetch_valid, trained && !dup_prefetch && !prefetch_rejected, "issue with conflicting flags")
    `PSP_ASSERT_IMP(a_no_hit_no_lead, done && !pend_match, lead_distance == '0, "lead distance without a pending hit")

endmodule

// ----- tb/sv/page_stride_prefetcher_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// page_stride_prefetcher_tb
// Self-checking testbench for the page stride prefetcher. A queue-fed driver
// sends directed and stream-shaped random accesses with random gaps. The
// threshold register is changed between phases. A monitor checks every result
// against a cycle-free model of the tracker and the pending CAM.
// ============================================================================
module page_stride_prefetcher_tb;

    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int NUM_STREAMS   = 16;
    localparam logic [psp_pkg::PAGE_W-1:0] PAGE_MAX = {psp_pkg::PAGE_W{1'b1}};

    typedef enum logic [1:0] {
        OP_ACCESS,
        OP_THRESH,
        OP_DRAIN
    } op_kind_t;

    typedef struct {
        op_kind_t                   kind;
        logic                       dem;
        logic [psp_pkg::IP_W-1:0]   ip;
        logic [psp_pkg::PAGE_W-1:0] page;
        logic                       acc;
        logic [psp_pkg::CONF_W-1:0] thresh;
    } access_op_t;

    typedef struct {
        logic [psp_pkg::IP_W-1:0]   ip;
        logic [psp_pkg::PAGE_W-1:0] page;
        int                         stride;
    } stream_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic                         is_demand = 1'b0;
    logic [psp_pkg::IP_W-1:0]     instr_pointer = '0;
    logic [psp_pkg::PAGE_W-1:0]   access_page = '0;
    logic                         issue_accepted = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [psp_pkg::CONF_W-1:0]   cfg_data = '0;
    logic                         done;
    logic                         prefetch_valid;
    logic [psp_pkg::PAGE_W-1:0]   prefetch_page;
    logic                         prefetch_rejected;
    logic                         pend_match;
    logic [psp_pkg::SEQ_W-1:0]    lead_distance;
    logic [psp_pkg::ROLE_W-1:0]   hit_role;
    logic [psp_pkg::PHASE_W-1:0]  hit_phase;
    logic                         trained;
    logic                         duplicate_page;
    logic                         dup_prefetch;
    logic                         pending_eviction;
    psp_pkg::psp_result_t         dut_res;

    page_stride_prefetcher u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .is_demand         (is_demand),
        .instr_pointer     (instr_pointer),
        .access_page       (access_page),
        .issue_accepted    (issue_accepted),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .done              (done),
        .prefetch_valid    (prefetch_valid),
        .prefetch_page     (prefetch_page),
        .prefetch_rejected (prefetch_rejected),
        .pend_match        (pend_match),
        .lead_distance     (lead_distance),
        .hit_role          (hit_role),
        .hit_phase         (hit_phase),
        .trained           (trained),
        .duplicate_page    (duplicate_page),
        .dup_prefetch      (dup_prefetch),
        .pending_eviction  (pending_eviction)
    );

    // Gather the result ports into one record
    always_comb
    begin
        dut_res.prefetch_valid    = prefetch_valid;
        dut_res.prefetch_page     = prefetch_page;
        dut_res.prefetch_rejected = prefetch_rejected;
        dut_res.pend_match        = pend_match;
        dut_res.lead_distance     = lead_distance;
        dut_res.hit_role          = hit_role;
        dut_res.hit_phase         = hit_phase;
        dut_res.trained           = trained;
        dut_res.duplicate_page    = duplicate_page;
        dut_res.dup_prefetch      = dup_prefetch;
        dut_res.pending_eviction  = pending_eviction;
    end

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prefetcher model state
    // ------------------------------------------------------------------
    logic [psp_pkg::CONF_W-1:0]   thresh_mdl = psp_pkg::THRESH_RESET;
    logic                         trk_valid [psp_pkg::TRK_DEPTH];
    logic [psp_pkg::IP_W-1:0]     trk_tag   [psp_pkg::TRK_DEPTH];
    logic [psp_pkg::PAGE_W-1:0]   trk_last  [psp_pkg::TRK_DEPTH];
    logic [psp_pkg::STRIDE_W-1:0] trk_stride[psp_pkg::TRK_DEPTH];
    logic [psp_pkg::CONF_W-1:0]   trk_conf  [psp_pkg::TRK_DEPTH];
    logic                         pend_live [psp_pkg::PEND_DEPTH];
    logic [psp_pkg::PAGE_W-1:0]   pend_page [psp_pkg::PEND_DEPTH];
    logic [psp_pkg::SEQ_W-1:0]    pend_seq  [psp_pkg::PEND_DEPTH];
    logic [psp_pkg::ROLE_W-1:0]   pend_role [psp_pkg::PEND_DEPTH];
    logic [psp_pkg::PHASE_W-1:0]  pend_phase[psp_pkg::PEND_DEPTH];
    logic [psp_pkg::PAGE_W-1:0]   issue_ring[psp_pkg::PEND_DEPTH];
    int                           issue_count = 0;
    int                           issue_head = 0;
    logic [psp_pkg::SEQ_W-1:0]    demand_cnt = '0;

    psp_pkg::psp_result_t         expected_results[$];
    access_op_t                   pending_ops[$];
    int                           err_count = 0;
    int                           n_access = 0, n_issue = 0, n_hit = 0, n_evict = 0;
    int                           n_dup_pred = 0, n_reject = 0;
    bit                           stim_done = 1'b0;

    initial
    begin
        for (int i = 0; i < psp_pkg::TRK_DEPTH; i++) trk_valid[i] = 1'b0;
        for (int i = 0; i < psp_pkg::PEND_DEPTH; i++) pend_live[i] = 1'b0;
    end

    function automatic int find_pending(logic [psp_pkg::PAGE_W-1:0] pg);
        for (int i = 0; i < psp_pkg::PEND_DEPTH; i++)
            if (pend_live[i] && pend_page[i] == pg)
                return i;
        return -1;
    endfunction

    function automatic void fill_pending(int s, logic [psp_pkg::PAGE_W-1:0] pg,
                                         logic [psp_pkg::ROLE_W-1:0] rl,
                                         logic [psp_pkg::PHASE_W-1:0] ph, logic live);
        issue_ring[s] = pg;
        pend_page[s]  = pg;
        pend_seq[s]   = demand_cnt;
        pend_role[s]  = rl;
        pend_phase[s] = ph;
        pend_live[s]  = live;
    endfunction

    // FIFO-ordered insert; returns 1 when a live entry was pushed out or the victim page equals the new one
    function automatic logic record_prefetch(logic [psp_pkg::PAGE_W-1:0] pg,
                                             logic [psp_pkg::ROLE_W-1:0] rl,
                                             logic [psp_pkg::PHASE_W-1:0] ph);
        int s;
        int victim_slot;
        logic [psp_pkg::PAGE_W-1:0] victim;
        if (issue_count < psp_pkg::PEND_DEPTH)
        begin
            fill_pending((issue_head + issue_count) % psp_pkg::PEND_DEPTH, pg, rl, ph, 1'b1);
            issue_count++;
            return 1'b0;
        end
        s = issue_head;
        issue_head = (s + 1) % psp_pkg::PEND_DEPTH;
        victim = issue_ring[s];
        if (victim == pg)
        begin
            fill_pending(s, pg, rl, ph, 1'b0);
            return 1'b1;
        end
        victim_slot = find_pending(victim);
        if (victim_slot >= 0) pend_live[victim_slot] = 1'b0;
        fill_pending(s, pg, rl, ph, 1'b1);
        return victim_slot >= 0;
    endfunction

    function automatic psp_pkg::psp_result_t predict_access(logic dem,
                                                            logic [psp_pkg::IP_W-1:0] ip,
                                                            logic [psp_pkg::PAGE_W-1:0] pg,
                                                            logic acc);
        psp_pkg::psp_result_t r;
        int slot;
        logic [psp_pkg::TRK_AW-1:0] idx;
        logic signed [psp_pkg::STRIDE_W:0] diff;
        logic [psp_pkg::STRIDE_W-1:0] strd;
        logic signed [psp_pkg::PRED_W:0] pred;
        r = '0;
        if (!dem || ip[1:0] >= psp_pkg::ROLE_LIMIT || ip[4:2] >= psp_pkg::PHASE_LIMIT)
            return r;
        demand_cnt++;
        slot = find_pending(pg);
        if (slot >= 0)
        begin
            r.pend_match    = 1'b1;
            r.lead_distance = demand_cnt - pend_seq[slot];
            r.hit_role      = pend_role[slot];
            r.hit_phase     = pend_phase[slot];
            pend_live[slot] = 1'b0;
        end
        // tracker training
        idx = ip[psp_pkg::TRK_AW-1:0];
        if (!trk_valid[idx] || trk_tag[idx] != ip)
        begin
            trk_valid[idx]  = 1'b1;
            trk_tag[idx]    = ip;
            trk_last[idx]   = pg;
            trk_stride[idx] = '0;
            trk_conf[idx]   = '0;
            r.trained = 1'b1;
            return r;
        end
        if (pg == trk_last[idx])
        begin
            r.duplicate_page = 1'b1;
            return r;
        end
        diff = $signed({2'b00, pg}) - $signed({2'b00, trk_last[idx]});
        strd = diff[psp_pkg::STRIDE_W-1:0];
        if (strd == trk_stride[idx])
        begin
            if (trk_conf[idx] < psp_pkg::CONF_MAX) trk_conf[idx]++;
        end
        else
        begin
            trk_stride[idx] = strd;
            trk_conf[idx]   = 3'd1;
        end
        trk_last[idx] = pg;
        r.trained = 1'b1;
        if (strd == '0 || trk_conf[idx] < thresh_mdl) return r;
        // prediction, dropped when off either end of the page space
        pred = $signed({3'b000, pg})
               + $signed({{2{strd[psp_pkg::STRIDE_W-1]}}, strd});
        if (pred[psp_pkg::PRED_W] || |pred[psp_pkg::PRED_W-1:psp_pkg::PAGE_W]) return r;
        r.prefetch_page = pred[psp_pkg::PAGE_W-1:0];
        if (find_pending(r.prefetch_page) >= 0)
        begin
            r.dup_prefetch = 1'b1;
            return r;
        end
        if (!acc)
        begin
            r.prefetch_rejected = 1'b1;
            return r;
        end
        r.prefetch_valid   = 1'b1;
        r.pending_eviction = record_prefetch(r.prefetch_page, ip[1:0], ip[4:2]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    stream_t streams[NUM_STREAMS];

    function automatic logic [psp_pkg::IP_W-1:0] valid_ip();
        logic [psp_pkg::IP_W-1:0] ip;
        ip = psp_pkg::IP_W'({$urandom, $urandom});
        ip[1:0] = 2'($urandom_range(0, 2));
        ip[4:2] = 3'($urandom_range(0, 6));
        return ip;
    endfunction

    function automatic void seed_stream(int k);
        int sel;
        sel = $urandom_range(0, 9);
        streams[k].ip = valid_ip();
        // a few streams alias another stream's tracker entry
        if (k > 0 && $urandom_range(0, 5) == 0)
            streams[k].ip[psp_pkg::TRK_AW-1:0] = streams[k-1].ip[psp_pkg::TRK_AW-1:0];
        streams[k].stride = int'($urandom_range(1, 8)) * ($urandom_range(0, 1) ? 1 : -1);
        if (sel == 0)
            streams[k].stride = int'($urandom_range(1, 1 << 20)) - (1 << 19);
        if (streams[k].stride == 0) streams[k].stride = 1;
        case (sel)
            1: streams[k].page = psp_pkg::PAGE_W'($urandom_range(0, 40));
            2: streams[k].page = PAGE_MAX - psp_pkg::PAGE_W'($urandom_range(0, 40));
            default: streams[k].page = psp_pkg::PAGE_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic void push_access(logic dem, logic [psp_pkg::IP_W-1:0] ip,
                                        logic [psp_pkg::PAGE_W-1:0] pg, logic acc);
        access_op_t op;
        op = '{OP_ACCESS, dem, ip, pg, acc, '0};
        pending_ops.insert(pending_ops.size(), op);
    endfunction

    function automatic void push_ctrl(op_kind_t kind, logic [psp_pkg::CONF_W-1:0] th);
        access_op_t op;
        op = '{kind, 1'b0, '0, '0, 1'b0, th};
        pending_ops.insert(pending_ops.size(), op);
    endfunction

    function automatic void push_random_access();
        int k;
        int roll;
        k = $urandom_range(0, NUM_STREAMS - 1);
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            // noise: anything goes, mostly ignored by the block
            push_access(1'($urandom), psp_pkg::IP_W'({$urandom, $urandom}),
                        psp_pkg::PAGE_W'({$urandom, $urandom}), 1'($urandom));
            return;
        end
        if (roll < 13) seed_stream(k);
        else if (roll < 18)
            streams[k].stride = int'($urandom_range(1, 8)) * ($urandom_range(0, 1) ? 1 : -1);
        if (roll >= 25)
            streams[k].page = streams[k].page + psp_pkg::PAGE_W'(streams[k].stride);
        push_access(1'b1, streams[k].ip, streams[k].page, $urandom_range(0, 9) != 0);
    endfunction

    logic [psp_pkg::CONF_W-1:0] phase_thresh[6] = '{3'd1, 3'd7, 3'd4, 3'd2, 3'd5, 3'd3};

    initial
    begin
        logic [psp_pkg::IP_W-1:0] ipa, ipb, ipc, ipd, ipe, ipf;
        ipa = 48'h0000_0000_0000;
        ipb = 48'hFFFF_FFFF_FFF8 & ~48'h3 | 48'h2;
        ipc = 48'h1234_5678_9A10;
        ipd = 48'h8000_0000_0014;
        ipe = 48'h0F0F_0F0F_0F05;
        ipf = 48'h7000_0000_0F05;
        // ignored accesses: no demand, role 3, phase 7
        push_access(1'b0, ipa, PAGE_MAX, 1'b1);
        push_access(1'b1, 48'hFFFF_FFFF_FFFF, PAGE_MAX, 1'b1);
        push_access(1'b1, 48'h0000_0000_001C, '0, 1'b1);
        // steady stride, issue at threshold then retire on the hit
        push_access(1'b1, ipa, 36'd10, 1'b1);
        push_access(1'b1, ipa, 36'd10, 1'b1);
        push_access(1'b1, ipa, 36'd20, 1'b1);
        push_access(1'b1, ipa, 36'd30, 1'b1);
        push_access(1'b1, ipa, 36'd40, 1'b1);
        // prediction below page zero
        push_access(1'b1, ipb, 36'd4, 1'b1);
        push_access(1'b1, ipb, 36'd2, 1'b1);
        push_access(1'b1, ipb, 36'd0, 1'b1);
        // prediction past the top page
        push_access(1'b1, ipc, PAGE_MAX - 36'd4, 1'b1);
        push_access(1'b1, ipc, PAGE_MAX - 36'd2, 1'b1);
        push_access(1'b1, ipc, PAGE_MAX, 1'b1);
        // queue refuses
        push_access(1'b1, ipd, 36'd500, 1'b0);
        push_access(1'b1, ipd, 36'd503, 1'b0);
        push_access(1'b1, ipd, 36'd506, 1'b0);
        // same prediction from two pointers, second is a duplicate
        push_access(1'b1, ipe, 36'd100, 1'b1);
        push_access(1'b1, ipe, 36'd110, 1'b1);
        push_access(1'b1, ipe, 36'd120, 1'b1);
        push_access(1'b1, ipf, 36'd100, 1'b1);
        push_access(1'b1, ipf, 36'd110, 1'b1);
        push_access(1'b1, ipf, 36'd120, 1'b1);
        // tag conflict on the same tracker entry
        push_access(1'b1, ipf ^ 48'h0100_0000_0000, 36'd130, 1'b1);

        for (int k = 0; k < NUM_STREAMS; k++) seed_stream(k);
        for (int p = 0; p < 6; p++)
        begin
            push_ctrl(OP_THRESH, phase_thresh[p]);
            for (int i = 0; i < 188; i++)
            begin
                push_random_access();
                if (p == 2 && i == 90) push_ctrl(OP_DRAIN, '0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    int gap_left = 0;
    int quiet_cycles = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        access_op_t op;
        if (!rst_n)
        begin
            start     <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            if (expected_results.size() == 0 && !start) quiet_cycles++;
            else quiet_cycles = 0;
            // register write completes
            if (cfg_valid && cfg_ready) thresh_mdl = cfg_data;
            // access transfer
            if (start && !busy)
            begin
                expected_results.insert(expected_results.size(),
                    predict_access(is_demand, instr_pointer, access_page, issue_accepted));
                n_access++;
                gap_left = pick_gap();
                if ($urandom_range(0, 199) == 0) gap_left = 0;
            end

            if (start && busy)
                ;
            else if (cfg_valid && !cfg_ready)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                start     <= 1'b0;
                cfg_valid <= 1'b0;
            end
            else if (pending_ops.size() == 0)
            begin
                start     <= 1'b0;
                cfg_valid <= 1'b0;
                stim_done = 1'b1;
            end
            else if (pending_ops[0].kind == OP_ACCESS)
            begin
                op = pending_ops[0];
                pending_ops.delete(0);
                start          <= 1'b1;
                cfg_valid      <= 1'b0;
                is_demand      <= op.dem;
                instr_pointer  <= op.ip;
                access_page    <= op.page;
                issue_accepted <= op.acc;
            end
            else if (quiet_cycles >= SETTLE_CYCLES && !cfg_valid)
            begin
                // block drained: write the threshold or just resume
                op = pending_ops[0];
                pending_ops.delete(0);
                start     <= 1'b0;
                cfg_valid <= (op.kind == OP_THRESH);
                cfg_data  <= op.thresh;
            end
            else
            begin
                start     <= 1'b0;
                cfg_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        psp_pkg::psp_result_t exp_r;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no access outstanding");
                err_count++;
            end
            else
            begin
                exp_r = expected_results[0];
                expected_results.delete(0);
                n_issue    += exp_r.prefetch_valid;
                n_hit      += exp_r.pend_match;
                n_evict    += exp_r.pending_eviction;
                n_dup_pred += exp_r.dup_prefetch;
                n_reject   += exp_r.prefetch_rejected;
                if (dut_res.prefetch_valid !== exp_r.prefetch_valid)
                begin
                    $error("prefetch_valid exp %0h got %0h",
                           exp_r.prefetch_valid, dut_res.prefetch_valid);
                    err_count++;
                end
                if (dut_res.prefetch_page !== exp_r.prefetch_page)
                begin
                    $error("prefetch_page exp %0h got %0h",
                           exp_r.prefetch_page, dut_res.prefetch_page);
                    err_count++;
                end
                if (dut_res.prefetch_rejected !== exp_r.prefetch_rejected)
                begin
                    $error("prefetch_rejected exp %0h got %0h",
                           exp_r.prefetch_rejected, dut_res.prefetch_rejected);
                    err_count++;
                end
                if (dut_res.pend_match !== exp_r.pend_match)
                begin
                    $error("pend_match exp %0h got %0h",
                           exp_r.pend_match, dut_res.pend_match);
                    err_count++;
                end
                if (dut_res.lead_distance !== exp_r.lead_distance)
                begin
                    $error("lead_distance exp %0h got %0h",
                           exp_r.lead_distance, dut_res.lead_distance);
                    err_count++;
                end
                if (dut_res.hit_role !== exp_r.hit_role)
                begin
                    $error("hit_role exp %0h got %0h", exp_r.hit_role, dut_res.hit_role);
                    err_count++;
                end
                if (dut_res.hit_phase !== exp_r.hit_phase)
                begin
                    $error("hit_phase exp %0h got %0h", exp_r.hit_phase, dut_res.hit_phase);
                    err_count++;
                end
                if (dut_res.trained !== exp_r.trained)
                begin
                    $error("trained exp %0h got %0h", exp_r.trained, dut_res.trained);
                    err_count++;
                end
                if (dut_res.duplicate_page !== exp_r.duplicate_page)
                begin
                    $error("duplicate_page exp %0h got %0h",
                           exp_r.duplicate_page, dut_res.duplicate_page);
                    err_count++;
                end
                if (dut_res.dup_prefetch !== exp_r.dup_prefetch)
                begin
                    $error("dup_prefetch exp %0h got %0h",
                           exp_r.dup_prefetch, dut_res.dup_prefetch);
                    err_count++;
                end
                if (dut_res.pending_eviction !== exp_r.pending_eviction)
                begin
                    $error("pending_eviction exp %0h got %0h",
                           exp_r.pending_eviction, dut_res.pending_eviction);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles without any transfer
    // ------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_valid) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        wait (expected_results.size() == 0);
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            err_count++;
        end
        $display("covered %0d accesses over 7 threshold settings: %0d issued, %0d hits,",
                 n_access, n_issue, n_hit);
        $display("%0d evictions, %0d duplicate predictions, %0d refused, %0d errors",
                 n_evict, n_dup_pred, n_reject, err_count);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
